/* hw/rtl/telnet_option_refusal_filter_assert.svh */
// Assertion macros shared by the telnet option refusal filter modules.
`ifndef TELNET_OPTION_REFUSAL_FILTER_ASSERT_SVH
`define TELNET_OPTION_REFUSAL_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF

`define TNOF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define TNOF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define TNOF_ASSERT(label, clk, rst, prop, msg)

`define TNOF_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

/* hw/rtl/tnof_pkg.sv */
// Shared constants, codes and types of the telnet option refusal filter.
package tnof_pkg;

   localparam int BUFFER_DEPTH = 4096;
   localparam int BYTE_WIDTH = 8;
   localparam int CAP_WIDTH = 13;
   localparam int INDEX_FIELD_WIDTH = 12;
   localparam int COUNT_WIDTH = $clog2(BUFFER_DEPTH + 1);
   localparam int WIDE_WIDTH = (CAP_WIDTH > COUNT_WIDTH) ? CAP_WIDTH : COUNT_WIDTH;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(4096);

   localparam logic [BYTE_WIDTH-1:0] TN_IAC = 8'd255;
   localparam logic [BYTE_WIDTH-1:0] TN_WILL = 8'd251;
   localparam logic [BYTE_WIDTH-1:0] TN_WONT = 8'd252;
   localparam logic [BYTE_WIDTH-1:0] TN_DO = 8'd253;
   localparam logic [BYTE_WIDTH-1:0] TN_DONT = 8'd254;
   localparam logic [BYTE_WIDTH-1:0] TN_OPT_SGA = 8'd3;

   typedef enum logic [2:0] {
      PHASE_DATA = 3'b001,
      PHASE_CMD  = 3'b010,
      PHASE_VERB = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      VERB_WILL = 2'd0,
      VERB_WONT = 2'd1,
      VERB_DO   = 2'd2,
      VERB_DONT = 2'd3
   } verb_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]        out_byte;
      logic                         to_peer;
      logic [INDEX_FIELD_WIDTH-1:0] write_index;
      logic                         last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0]       count;
      result_type [2:0] entry;
   } run_type;

endpackage

/* hw/rtl/tnof_parser.sv */
// Command parser, payload counter and capacity register of the filter.
`include "telnet_option_refusal_filter_assert.svh"

module tnof_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [tnof_pkg::CAP_WIDTH-1:0]      csr_write_data,
   input  logic                                accept,
   input  logic [tnof_pkg::BYTE_WIDTH-1:0]     rx_byte,
   input  logic                                restart,
   output tnof_pkg::run_type                   run
);
   import tnof_pkg::*;

   logic [CAP_WIDTH-1:0]   capacity_ff;
   phase_type              phase_ff, phase_in;
   verb_type               verb_ff, verb_in;
   logic [COUNT_WIDTH-1:0] stored_count_ff, stored_count_in;

   logic [COUNT_WIDTH-1:0] count_base;
   logic [WIDE_WIDTH-1:0]  count_wide;
   logic [WIDE_WIDTH-1:0]  cap_wide;
   logic [WIDE_WIDTH-1:0]  depth_wide;
   logic [WIDE_WIDTH-1:0]  limit;
   logic                   room;
   logic                   store;
   logic                   store_ok;
   logic [BYTE_WIDTH-1:0]  reply;

   function automatic logic [BYTE_WIDTH-1:0] reply_verb(verb_type verb,
                                                         logic [BYTE_WIDTH-1:0] opt);
      logic [BYTE_WIDTH-1:0] answer;
      case (verb)
         VERB_WONT: answer = TN_DONT;
         VERB_DONT: answer = TN_WONT;
         VERB_DO:   answer = (opt == TN_OPT_SGA) ? TN_WILL : TN_WONT;
         default:   answer = (opt == TN_OPT_SGA) ? TN_DO : TN_DONT;
      endcase
      return answer;
   endfunction

   always_comb begin
      count_base = restart ? '0 : stored_count_ff;
      count_wide = WIDE_WIDTH'(count_base);
      cap_wide = WIDE_WIDTH'(capacity_ff);
      depth_wide = WIDE_WIDTH'(BUFFER_DEPTH);
      limit = (cap_wide > depth_wide) ? depth_wide : cap_wide;
      room = count_wide < limit;
      reply = reply_verb(verb_ff, rx_byte);

      store = 1'b0;
      phase_in = PHASE_DATA;
      verb_in = verb_ff;
      run = '0;

      case (phase_ff)
         PHASE_CMD: begin
            if (rx_byte == TN_IAC) begin
               store = 1'b1;
            end else if (rx_byte >= TN_WILL && rx_byte <= TN_DONT) begin
               verb_in = verb_type'(rx_byte[1:0] + 2'd1);
               phase_in = PHASE_VERB;
            end
         end
         PHASE_VERB: begin
            run.count = 2'd3;
            run.entry[0] = '{out_byte: TN_IAC, to_peer: 1'b1, write_index: '0,
                             last_of_run: 1'b0};
            run.entry[1] = '{out_byte: reply, to_peer: 1'b1, write_index: '0,
                             last_of_run: 1'b0};
            run.entry[2] = '{out_byte: rx_byte, to_peer: 1'b1, write_index: '0,
                             last_of_run: 1'b1};
         end
         default: begin
            if (rx_byte == TN_IAC) begin
               phase_in = PHASE_CMD;
            end else begin
               store = 1'b1;
            end
         end
      endcase

      store_ok = store && room;
      if (store_ok) begin
         run.count = 2'd1;
         run.entry[0] = '{out_byte: rx_byte, to_peer: 1'b0,
                          write_index: count_wide[INDEX_FIELD_WIDTH-1:0],
                          last_of_run: 1'b1};
      end
      stored_count_in = store_ok ? count_base + COUNT_WIDTH'(1) : count_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         phase_ff <= PHASE_DATA;
         verb_ff <= VERB_WILL;
         stored_count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            verb_ff <= verb_in;
            stored_count_ff <= stored_count_in;
         end
      end
   end

   `TNOF_ASSERT_NEXT(a_count_step, clock, reset, accept && !restart, stored_count_ff == $past(stored_count_ff) || stored_count_ff == $past(stored_count_ff) + COUNT_WIDTH'(1), "Stored count moved by more than one byte.")

endmodule

/* hw/rtl/tnof_reply_queue.sv */
// Result register that holds one run of up to three results and drains it.
`include "telnet_option_refusal_filter_assert.svh"

module tnof_reply_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  tnof_pkg::run_type                      run,
   output logic                                   ready,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tnof_pkg::BYTE_WIDTH-1:0]        rsp_out_byte,
   output logic                                   rsp_to_peer,
   output logic [tnof_pkg::INDEX_FIELD_WIDTH-1:0] rsp_write_index,
   output logic                                   rsp_last_of_run
);
   import tnof_pkg::*;

   result_type [2:0] entry_ff, entry_in;
   logic [1:0]       remaining_ff, remaining_in;

   result_type head;
   logic       take;
   logic       load;

   always_comb begin
      head = entry_ff[0];
      rsp_valid = remaining_ff != 2'd0;
      take = rsp_valid && !rsp_stall;
      ready = (remaining_ff == 2'd0) || (remaining_ff == 2'd1 && !rsp_stall);
      load = accept && run.count != 2'd0;

      entry_in = entry_ff;
      remaining_in = remaining_ff;
      if (load) begin
         entry_in = run.entry;
         remaining_in = run.count;
      end else if (take) begin
         entry_in[0] = entry_ff[1];
         entry_in[1] = entry_ff[2];
         remaining_in = remaining_ff - 2'd1;
      end

      rsp_out_byte = head.out_byte;
      rsp_to_peer = head.to_peer;
      rsp_write_index = head.write_index;
      rsp_last_of_run = head.last_of_run;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 2'd0;
      end else begin
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   `TNOF_ASSERT(a_last_on_final, clock, reset, rsp_valid |-> (head.last_of_run == (remaining_ff == 2'd1)), "Last-of-run flag does not mark the final result.")
   `TNOF_ASSERT(a_load_when_free, clock, reset, load |-> (remaining_ff == 2'd0 || (remaining_ff == 2'd1 && take)), "A new run overwrote results still waiting.")
   `TNOF_ASSERT(a_reply_index_zero, clock, reset, (rsp_valid && head.to_peer) |-> (head.write_index == '0), "A reply result carries a nonzero write index.")

endmodule

/* hw/rtl/telnet_option_refusal_filter.sv */
// Top level of the telnet option refusal filter.
// Each request is parsed in the cycle it is accepted; its results appear in the next cycle.
// A payload or command byte gives at most one result: plain data streams at one request a cycle
// while the output does not stall. A negotiation reply is a run of three results, drained from
// the result register one a cycle unless stalled, so the next request waits until two have left.
// Synchronous reset sets the capacity to 4096, clears the stored count and the parse phase.
module telnet_option_refusal_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [tnof_pkg::CAP_WIDTH-1:0]         csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [tnof_pkg::BYTE_WIDTH-1:0]        req_rx_byte,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tnof_pkg::BYTE_WIDTH-1:0]        rsp_out_byte,
   output logic                                   rsp_to_peer,
   output logic [tnof_pkg::INDEX_FIELD_WIDTH-1:0] rsp_write_index,
   output logic                                   rsp_last_of_run
);
   import tnof_pkg::*;

   run_type run;
   logic    ready;
   logic    accept;

   assign req_stall = !ready;
   assign accept = req_valid && ready;

   tnof_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .rx_byte          (req_rx_byte),
      .restart          (req_restart),
      .run              (run)
   );

   tnof_reply_queue u_reply_queue (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .run             (run),
      .ready           (ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_to_peer     (rsp_to_peer),
      .rsp_write_index (rsp_write_index),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
